/* design/ipmd5_pkg.sv */
// Shared types, constants and helper functions of the IPv4 packet MD5 identifier.
// Used by ipmd5_core and by the top level ip_packet_md5_identifier.
`timescale 1ns / 1ps
package ipmd5_pkg;

   // identifier layout
   localparam int IDENT_LEN        = 56;
   localparam int HEADER_ID_LEN    = 13;
   localparam int FIXED_HEADER_END = 20;
   localparam int PAYLOAD_LEN      = IDENT_LEN - HEADER_ID_LEN;
   localparam logic [3:0] IHL_MASK = 4'hf;

   // top level sequencer states
   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_LOAD,
      ST_ROUND,
      ST_OUT
   } ipmd5_state_type;

   // hash core states
   typedef enum logic [1:0] {
      CS_IDLE,
      CS_RUN,
      CS_ADD
   } ipmd5_core_state_type;

   // control from the sequencer to the hash core
   typedef struct packed {
      logic       msg_we;
      logic [5:0] msg_idx;
      logic [7:0] msg_byte;
      logic       start;
      logic       init;
   } ipmd5_core_ctl_type;

   // md5 initial chaining values
   localparam logic [31:0] MD5_IV [4] = '{32'h67452301, 32'hefcdab89,
                                          32'h98badcfe, 32'h10325476};

   // md5 round constants
   localparam logic [31:0] MD5_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};

   // md5 rotate amounts, indexed by {round group, round[1:0]}
   localparam logic [4:0] MD5_S [16] = '{5'd7, 5'd12, 5'd17, 5'd22,
                                         5'd5, 5'd9,  5'd14, 5'd20,
                                         5'd4, 5'd11, 5'd16, 5'd23,
                                         5'd6, 5'd10, 5'd15, 5'd21};

   // rotate left by a nonzero amount
   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
      logic [63:0] w;
      w = {x, x} << s;
      return w[63:32];
   endfunction

   // reverse byte order of a word
   function automatic logic [31:0] bswap(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

endpackage

/* design/ipmd5_core.sv */
// MD5 compression unit: 16-word block buffer, chaining words, sum-then-update rounds.
// Depends on ipmd5_pkg.
`timescale 1ns / 1ps
module ipmd5_core import ipmd5_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  ipmd5_core_ctl_type ctl,
   output logic               done,
   output logic [127:0]       hash
);

   ipmd5_core_state_type cs_ff, cs_in;
   logic [5:0]  rnd_ff;
   logic        ph_ff;
   logic [31:0] msg_ff [16];
   logic [31:0] hash_ff [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] sum_ff;
   logic [3:0]  r;
   logic [3:0]  g;
   logic [31:0] f;
   logic [31:0] t;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         cs_ff <= CS_IDLE;
      end else begin
         cs_ff <= cs_in;
      end
   end

   // next state
   always_comb begin
      cs_in = cs_ff;
      case (cs_ff)
         CS_IDLE: begin
            if (ctl.start) cs_in = CS_RUN;
         end
         CS_RUN: begin
            if (ph_ff && rnd_ff == 6'd63) cs_in = CS_ADD;
         end
         CS_ADD: begin
            cs_in = CS_IDLE;
         end
         default: begin
            cs_in = CS_IDLE;
         end
      endcase
   end

   // message index and round function
   assign r = rnd_ff[3:0];
   always_comb begin
      case (rnd_ff[5:4])
         2'd0: begin
            g = r;
            f = (b_ff & c_ff) | (~b_ff & d_ff);
         end
         2'd1: begin
            g = 4'(r * 4'd5 + 4'd1);
            f = (d_ff & b_ff) | (~d_ff & c_ff);
         end
         2'd2: begin
            g = 4'(r * 4'd3 + 4'd5);
            f = b_ff ^ c_ff ^ d_ff;
         end
         default: begin
            g = 4'(r * 4'd7);
            f = c_ff ^ (b_ff | ~d_ff);
         end
      endcase
   end
   assign t = sum_ff + f;

   // round counter
   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_ff <= '0;
         ph_ff  <= 1'b0;
      end else if (ctl.start) begin
         rnd_ff <= '0;
         ph_ff  <= 1'b0;
      end else if (cs_ff == CS_RUN) begin
         ph_ff <= ~ph_ff;
         if (ph_ff) rnd_ff <= rnd_ff + 6'd1;
      end
   end

   // block buffer, working words and chaining words
   always_ff @(posedge clock) begin
      if (ctl.msg_we) msg_ff[ctl.msg_idx[5:2]][{ctl.msg_idx[1:0], 3'b000} +: 8] <= ctl.msg_byte;
      if (ctl.start) begin
         if (ctl.init) begin
            hash_ff <= MD5_IV;
            a_ff    <= MD5_IV[0];
            b_ff    <= MD5_IV[1];
            c_ff    <= MD5_IV[2];
            d_ff    <= MD5_IV[3];
         end else begin
            a_ff <= hash_ff[0];
            b_ff <= hash_ff[1];
            c_ff <= hash_ff[2];
            d_ff <= hash_ff[3];
         end
      end else if (cs_ff == CS_RUN) begin
         if (!ph_ff) begin
            sum_ff <= a_ff + MD5_K[rnd_ff] + msg_ff[g];
         end else begin
            a_ff <= d_ff;
            d_ff <= c_ff;
            c_ff <= b_ff;
            b_ff <= b_ff + rotl(t, MD5_S[{rnd_ff[5:4], rnd_ff[1:0]}]);
         end
      end else if (cs_ff == CS_ADD) begin
         hash_ff[0] <= hash_ff[0] + a_ff;
         hash_ff[1] <= hash_ff[1] + b_ff;
         hash_ff[2] <= hash_ff[2] + c_ff;
         hash_ff[3] <= hash_ff[3] + d_ff;
      end
   end

   assign done = (cs_ff == CS_ADD);
   assign hash = {hash_ff[3], hash_ff[2], hash_ff[1], hash_ff[0]};

endmodule

/* design/ip_packet_md5_identifier.sv */
// Top level of the IPv4 packet MD5 identifier: byte collector, identifier memory, sequencer.
// Depends on ipmd5_pkg and ipmd5_core.
`timescale 1ns / 1ps
// The block takes one packet byte per cycle on the req side while collecting, except that a
// byte that lands both in a header field slot and in the payload window holds off the next
// byte while its second write is made, since the 56-byte identifier memory has a single
// write port. On the last byte the identifier is read out of memory into the hash core one
// 64-byte block at a time and hashed one MD5 round at a time, each block ending with the
// chaining add. Identifiers of 56 bytes take two blocks, shorter ones one. Bytes of the
// next packet are not taken while a digest is formed; a finished result waits in the rsp
// register while the next packet is collected.
module ip_packet_md5_identifier import ipmd5_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // packet_byte
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // digest_high, digest_low, ident_length, zero fill
   output logic         rsp_tuser    // status
);

   ipmd5_state_type    state_ff, state_in;
   ipmd5_core_ctl_type core_ctl;
   logic               core_done;
   logic [127:0]       core_hash;

   logic [15:0] pos_ff, pos_in;
   logic [15:0] tlen_ff, tlen_in;
   logic [5:0]  hlen_ff, hlen_in;
   logic [7:0]  fb_ff [4];
   logic [7:0]  ident_mem [IDENT_LEN];
   logic [IDENT_LEN-1:0] valid_ff;
   logic [7:0]  rd_data_ff;
   logic [5:0]  rd_addr;
   logic        pend_ff;
   logic [5:0]  pend_addr_ff;
   logic [7:0]  pend_data_ff;
   logic        accept;
   logic        pos_ok;
   logic        case_hdr, case_tail;
   logic [15:0] win_start;
   logic [5:0]  win_cnt;
   logic [15:0] pl_off;
   logic        pl_hit;
   logic [5:0]  pl_idx;
   logic        hdr_hit;
   logic [5:0]  hdr_idx;
   logic        placing;
   logic        wr_en;
   logic [5:0]  wr_addr;
   logic [7:0]  wr_data;
   logic        pend_set;
   logic        status_ff;
   logic [5:0]  len_ff;
   logic        dbl_ff;
   logic        ovr_ff;
   logic        blk_ff;
   logic [6:0]  cnt_ff;
   logic [5:0]  g_lo;
   logic        in_ident, ovr_hit, pad_hit, tail_hit;
   logic        ld_mem_ff;
   logic [7:0]  ld_const_ff;
   logic [7:0]  ld_const;
   logic        out_load;
   logic        rsp_valid_ff;
   logic [135:0] rsp_data_ff;
   logic        rsp_user_ff;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_COLLECT) && !pend_ff;
   assign pos_ok     = (pos_ff != 16'hffff);

   // header fields as updated by this word
   always_comb begin
      tlen_in = tlen_ff;
      hlen_in = hlen_ff;
      pos_in  = pos_ff;
      if (accept && pos_ok) begin
         pos_in = pos_ff + 16'd1;
         if (pos_ff == 16'd0) hlen_in = {req_tdata[3:0] & IHL_MASK, 2'b00};
         if (pos_ff == 16'd2) tlen_in = {req_tdata, tlen_ff[7:0]};
         if (pos_ff == 16'd3) tlen_in = {tlen_ff[15:8], req_tdata};
      end
   end

   // payload window from total length and header length
   always_comb begin
      case_hdr  = {1'b0, tlen_in} >= 17'({11'd0, hlen_in} + PAYLOAD_LEN);
      case_tail = tlen_in >= 16'(FIXED_HEADER_END + PAYLOAD_LEN);
      if (case_hdr) begin
         win_start = {10'd0, hlen_in};
         win_cnt   = 6'(PAYLOAD_LEN);
      end else if (case_tail) begin
         win_start = tlen_in - 16'(PAYLOAD_LEN);
         win_cnt   = 6'(PAYLOAD_LEN);
      end else begin
         win_start = 16'(FIXED_HEADER_END);
         win_cnt   = (tlen_in > 16'(FIXED_HEADER_END))
                     ? 6'(tlen_in - 16'(FIXED_HEADER_END)) : 6'd0;
      end
   end

   assign pl_off = pos_ff - win_start;
   assign pl_hit = (pos_ff >= win_start) && (pl_off < {10'd0, win_cnt});
   assign pl_idx = 6'(HEADER_ID_LEN) + pl_off[5:0];

   // header field slots
   always_comb begin
      hdr_hit = 1'b1;
      hdr_idx = '0;
      case (pos_ff)
         16'd4:   hdr_idx = 6'd2;
         16'd5:   hdr_idx = 6'd3;
         16'd9:   hdr_idx = 6'd4;
         default: begin
            if (pos_ff >= 16'd12 && pos_ff <= 16'd19) hdr_idx = 6'(pos_ff - 16'd7);
            else hdr_hit = 1'b0;
         end
      endcase
   end

   assign placing = pos_ok && (pos_ff >= 16'd4) && (pos_ff < tlen_ff);

   // identifier memory write port
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = req_tdata;
      pend_set = 1'b0;
      if (pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = pend_addr_ff;
         wr_data = pend_data_ff;
      end else if (accept && pos_ok) begin
         if (pos_ff == 16'd2 || pos_ff == 16'd3) begin
            wr_en   = 1'b1;
            wr_addr = 6'(pos_ff - 16'd2);
         end else if (placing && hdr_hit) begin
            wr_en    = 1'b1;
            wr_addr  = hdr_idx;
            pend_set = pl_hit;
         end else if (placing && pl_hit) begin
            wr_en   = 1'b1;
            wr_addr = pl_idx;
         end
      end
   end

   // identifier memory
   always_ff @(posedge clock) begin
      if (wr_en) ident_mem[wr_addr] <= wr_data;
      rd_data_ff <= ident_mem[rd_addr];
   end

   // second write of a word that hits both a header slot and the window
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_set;
      end
      if (pend_set) begin
         pend_addr_ff <= pl_idx;
         pend_data_ff <= req_tdata;
      end
   end

   // packet tracking; written marks read back as zero when clear
   always_ff @(posedge clock) begin
      if (reset || out_load) begin
         pos_ff   <= '0;
         tlen_ff  <= '0;
         hlen_ff  <= '0;
         valid_ff <= '0;
         fb_ff    <= '{default: 8'd0};
      end else begin
         pos_ff  <= pos_in;
         tlen_ff <= tlen_in;
         hlen_ff <= hlen_in;
         if (wr_en) valid_ff[wr_addr] <= 1'b1;
         if (accept && pos_ok && pos_ff < 16'd4) fb_ff[pos_ff[1:0]] <= req_tdata;
      end
   end

   // result facts taken at the last word
   always_ff @(posedge clock) begin
      if (accept && req_tlast) begin
         status_ff <= (pos_in < tlen_in) || (pos_in < 16'(FIXED_HEADER_END));
         len_ff    <= 6'(HEADER_ID_LEN) + win_cnt;
         dbl_ff    <= (6'(HEADER_ID_LEN) + win_cnt) == 6'(IDENT_LEN);
         ovr_ff    <= case_hdr && (hlen_in == 6'd0);
      end
   end

   // byte source for block readout
   assign g_lo     = cnt_ff[5:0];
   assign in_ident = !blk_ff && (g_lo < len_ff);
   assign ovr_hit  = in_ident && ovr_ff && (g_lo >= 6'd13) && (g_lo <= 6'd16);
   assign pad_hit  = !blk_ff && (g_lo == len_ff);
   assign tail_hit = (blk_ff == dbl_ff);
   assign rd_addr  = (g_lo < 6'(IDENT_LEN)) ? g_lo : 6'd0;
   always_comb begin
      ld_const = 8'd0;
      if (ovr_hit) ld_const = fb_ff[2'(g_lo - 6'd13)];
      else if (pad_hit) ld_const = 8'h80;
      else if (!in_ident && tail_hit && g_lo == 6'd56) ld_const = {len_ff[4:0], 3'b000};
      else if (!in_ident && tail_hit && g_lo == 6'd57) ld_const = {7'd0, len_ff[5]};
   end

   // readout pipeline and block counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         blk_ff <= 1'b0;
      end else if (state_ff == ST_COLLECT) begin
         cnt_ff <= '0;
         blk_ff <= 1'b0;
      end else if (state_ff == ST_LOAD && !pend_ff) begin
         cnt_ff <= cnt_ff + 7'd1;
      end else if (state_ff == ST_ROUND && core_done) begin
         cnt_ff <= '0;
         blk_ff <= 1'b1;
      end
      ld_mem_ff   <= in_ident && !ovr_hit && valid_ff[rd_addr];
      ld_const_ff <= ld_const;
   end

   // core control
   always_comb begin
      core_ctl.msg_we   = (state_ff == ST_LOAD) && !pend_ff && (cnt_ff != 7'd0);
      core_ctl.msg_idx  = 6'(cnt_ff - 7'd1);
      core_ctl.msg_byte = ld_mem_ff ? rd_data_ff : ld_const_ff;
      core_ctl.start    = (state_ff == ST_LOAD) && !pend_ff && (cnt_ff == 7'd64);
      core_ctl.init     = !blk_ff;
   end

   ipmd5_core u_core (
      .clock (clock),
      .reset (reset),
      .ctl   (core_ctl),
      .done  (core_done),
      .hash  (core_hash)
   );

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_COLLECT: begin
            if (accept && req_tlast) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (core_ctl.start) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (core_done) state_in = (!blk_ff && dbl_ff) ? ST_LOAD : ST_OUT;
         end
         ST_OUT: begin
            if (out_load) state_in = ST_COLLECT;
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_data_ff <= {2'b00, len_ff,
                         bswap(core_hash[95:64]), bswap(core_hash[127:96]),
                         bswap(core_hash[31:0]), bswap(core_hash[63:32])};
         rsp_user_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // checks
   a_ready_only_collect: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == ST_COLLECT) && !pend_ff)
      else $error("req_tready outside collect");
   a_pend_one_cycle: assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> !pend_ff)
      else $error("second write held more than one cycle");
   a_done_in_round: assert property (@(posedge clock) disable iff (reset)
      core_done |-> state_ff == ST_ROUND)
      else $error("hash core finished outside round state");
   a_start_after_load: assert property (@(posedge clock) disable iff (reset)
      core_ctl.start |=> state_ff == ST_ROUND)
      else $error("core start without round state");

endmodule

/* test/testbench.sv */
// Self-checking testbench of ip_packet_md5_identifier: packets go in as byte words, and each
// digest result is checked against an internal identifier builder and MD5 predictor.
// Depends on ipmd5_pkg and the design top level only.
`timescale 1ns / 1ps
module testbench;
   import ipmd5_pkg::*;

   typedef struct {
      logic [7:0] data;
      logic       last;
      logic       drain;
   } byte_word_type;

   typedef struct {
      logic [63:0] dig_hi;
      logic [63:0] dig_lo;
      logic [5:0]  id_len;
      logic        short_pkt;
   } digest_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;   // packet_byte
   logic         req_tlast = 1'b0; // last_byte
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;        // digest_high, digest_low, ident_length, zero fill
   logic         rsp_tuser;        // status

   byte_word_type byte_q[$];
   digest_type    digest_q[$];
   int            fail_count = 0;
   int            req_gap = 0;
   int            rsp_gap = 0;
   logic          req_taken = 1'b0;
   logic          quiet = 1'b0;

   // packet assembly state of the predictor
   int          pkt_pos;
   int          pkt_total;
   int          pkt_hdr;
   logic [7:0]  id_bytes [IDENT_LEN];
   logic [7:0]  lead_bytes [2];

   ip_packet_md5_identifier i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #1 clock = ~clock;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      fail_count++;
   endtask

   function automatic void clear_packet();
      pkt_pos = 0;
      pkt_total = 0;
      pkt_hdr = 0;
      foreach (id_bytes[i]) id_bytes[i] = 8'h00;
      lead_bytes[0] = 8'h00;
      lead_bytes[1] = 8'h00;
   endfunction

   // payload window from stated length and header length
   function automatic void payload_window(output int start, output int count);
      if (pkt_total >= pkt_hdr + PAYLOAD_LEN) begin
         start = pkt_hdr;
         count = PAYLOAD_LEN;
      end else if (pkt_total >= FIXED_HEADER_END + PAYLOAD_LEN) begin
         start = pkt_total - PAYLOAD_LEN;
         count = PAYLOAD_LEN;
      end else begin
         start = FIXED_HEADER_END;
         count = (pkt_total > FIXED_HEADER_END) ? pkt_total - FIXED_HEADER_END : 0;
      end
   endfunction

   function automatic void put_window(input int pos, input logic [7:0] b);
      int start, count;
      payload_window(start, count);
      if (pos >= start && pos - start < count && HEADER_ID_LEN + pos - start < IDENT_LEN)
         id_bytes[HEADER_ID_LEN + pos - start] = b;
   endfunction

   function automatic logic [31:0] rot_left(input logic [31:0] x, input int s);
      return (x << s) | (x >> (32 - s));
   endfunction

   // md5 over len identifier bytes, digest bytes in output order
   function automatic logic [127:0] md5_of_ident(input int len);
      logic [7:0]  msg [192];
      logic [31:0] h [4];
      logic [31:0] m [16];
      logic [31:0] a, b, c, d, f, t;
      logic [63:0] bits;
      logic [127:0] dig;
      int nblk, g;
      foreach (msg[i]) msg[i] = 8'h00;
      for (int i = 0; i < len; i++) msg[i] = id_bytes[i];
      msg[len] = 8'h80;
      nblk = (len + 9 + 63) / 64;
      bits = 64'(len) * 8;
      for (int i = 0; i < 8; i++) msg[nblk * 64 - 8 + i] = bits[8 * i +: 8];
      for (int i = 0; i < 4; i++) h[i] = MD5_IV[i];
      for (int k = 0; k < nblk; k++) begin
         for (int i = 0; i < 16; i++)
            m[i] = {msg[64*k+4*i+3], msg[64*k+4*i+2], msg[64*k+4*i+1], msg[64*k+4*i]};
         a = h[0]; b = h[1]; c = h[2]; d = h[3];
         for (int i = 0; i < 64; i++) begin
            if (i < 16) begin
               f = (b & c) | (~b & d); g = i;
            end else if (i < 32) begin
               f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
            end else if (i < 48) begin
               f = b ^ c ^ d; g = (3 * i + 5) % 16;
            end else begin
               f = c ^ (b | ~d); g = (7 * i) % 16;
            end
            t = d; d = c; c = b;
            b = b + rot_left(a + f + MD5_K[i] + m[g], MD5_S[((i / 16) * 4) + (i % 4)]);
            a = t;
         end
         h[0] += a; h[1] += b; h[2] += c; h[3] += d;
      end
      for (int i = 0; i < 16; i++) dig[127 - 8 * i -: 8] = h[i / 4][8 * (i % 4) +: 8];
      return dig;
   endfunction

   // absorb one accepted byte, queue a digest on the last one
   function automatic void absorb_byte(input logic [7:0] b, input logic last);
      int start, count, len;
      logic [7:0] v;
      logic [127:0] dig;
      digest_type exp;
      if (pkt_pos < 16'hffff) begin
         if (pkt_pos == 0) begin
            lead_bytes[0] = b;
            pkt_hdr = int'(b & 8'h0f) * 4;
         end else if (pkt_pos == 1) lead_bytes[1] = b;
         else if (pkt_pos == 2) pkt_total = (pkt_total & 255) | (int'(b) << 8);
         else if (pkt_pos == 3) pkt_total = (pkt_total & 16'hff00) | int'(b);
         if (pkt_pos >= 4) begin
            if (pkt_pos < pkt_total) begin
               case (pkt_pos)
                  4, 5: id_bytes[pkt_pos - 2] = b;
                  9: id_bytes[4] = b;
                  default: if (pkt_pos >= 12 && pkt_pos <= 19) id_bytes[pkt_pos - 7] = b;
               endcase
               put_window(pkt_pos, b);
            end
         end else if (pkt_pos >= 2) id_bytes[pkt_pos - 2] = b;
         pkt_pos++;
      end
      if (!last) return;
      // window bytes 0..1 come from the saved leading bytes, 2..3 from the identifier
      for (int q = 0; q < 4; q++) begin
         v = (q < 2) ? lead_bytes[q] : id_bytes[q - 2];
         if (q < pkt_total) put_window(q, v);
      end
      payload_window(start, count);
      len = HEADER_ID_LEN + count;
      if (len > IDENT_LEN) len = IDENT_LEN;
      dig = md5_of_ident(len);
      exp.dig_hi = dig[127:64];
      exp.dig_lo = dig[63:0];
      exp.id_len = 6'(len);
      exp.short_pkt = (pkt_pos < pkt_total || pkt_pos < FIXED_HEADER_END);
      digest_q.push_back(exp);
      clear_packet();
   endfunction

   // queue one packet: header length, stated total, bytes supplied
   task automatic queue_packet(input int ihl, input int total, input int n, input logic drain);
      byte_word_type w;
      for (int i = 0; i < n; i++) begin
         w.data = 8'($urandom);
         if (i == 0) w.data = {w.data[7:4], 4'(ihl)};
         if (i == 2) w.data = total[15:8];
         if (i == 3) w.data = total[7:0];
         w.last = (i == n - 1);
         w.drain = drain && (i == 0);
         byte_q.push_back(w);
      end
   endtask

   task automatic queue_random_packet(input logic drain);
      int ihl, total, n, kind, hdr;
      ihl = $urandom_range(0, 15);
      hdr = ihl * 4;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2: total = $urandom_range(hdr + PAYLOAD_LEN, hdr + PAYLOAD_LEN + 20);
         3, 4: total = (hdr + PAYLOAD_LEN - 1 >= FIXED_HEADER_END + PAYLOAD_LEN) ?
                       $urandom_range(FIXED_HEADER_END + PAYLOAD_LEN, hdr + PAYLOAD_LEN - 1) :
                       $urandom_range(hdr + PAYLOAD_LEN, hdr + PAYLOAD_LEN + 5);
         default: total = $urandom_range(0, FIXED_HEADER_END + PAYLOAD_LEN - 1);
      endcase
      n = total;
      if (kind == 5) n = $urandom_range(1, total + 1);
      if (kind == 6) n = total + $urandom_range(1, 10);
      if (n < 1) n = 1;
      if (kind == 9) begin
         total = $urandom_range(0, 16'hffff);
         n = $urandom_range(1, 80);
      end
      queue_packet(ihl, total, n, drain);
   endtask

   // byte driver: new words at the falling edge
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         req_taken = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (byte_q.size() > 0 && byte_q[0].drain && digest_q.size() > 0) begin
            req_tvalid <= 1'b0;
         end else if (byte_q.size() > 0) begin
            if (!quiet && $urandom_range(0, 15) == 0) begin
               req_gap = $urandom_range(0, 17);
               req_tvalid <= 1'b0;
            end else begin
               byte_q[0].drain = 1'b0;
               req_tdata <= byte_q[0].data;
               req_tlast <= byte_q[0].last;
               req_tvalid <= 1'b1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      // result side stall bursts
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(0, 17);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // accept bytes and check results at the rising edge
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready && !req_taken) begin
         absorb_byte(req_tdata, req_tlast);
         void'(byte_q.pop_front());
         req_taken = 1'b1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digest_q.size() == 0) begin
            report("unexpected word", rsp_tdata[63:0], 64'h0);
         end else begin
            if (rsp_tdata[63:0] !== digest_q[0].dig_hi)
               report("digest_high", rsp_tdata[63:0], digest_q[0].dig_hi);
            if (rsp_tdata[127:64] !== digest_q[0].dig_lo)
               report("digest_low", rsp_tdata[127:64], digest_q[0].dig_lo);
            if (rsp_tdata[133:128] !== digest_q[0].id_len)
               report("ident_length", 64'(rsp_tdata[133:128]), 64'(digest_q[0].id_len));
            if (rsp_tuser !== digest_q[0].short_pkt)
               report("status", 64'(rsp_tuser), 64'(digest_q[0].short_pkt));
            void'(digest_q.pop_front());
         end
      end
   end

   // run time limit
   initial begin
      #4000000;
      $display("testbench failed");
      $finish;
   end

   initial begin
      clear_packet();
      // directed: single byte, negative copy length, ihl zero, truncated, excess, ihl one
      queue_packet(5, 16'h0000, 1, 1'b0);
      queue_packet(5, 10, 10, 1'b0);
      queue_packet(0, 50, 50, 1'b0);
      queue_packet(15, 16'hffff, 8, 1'b0);
      queue_packet(5, 22, 26, 1'b0);
      queue_packet(1, 70, 70, 1'b0);
      while (byte_q.size() < 1400) queue_random_packet($urandom_range(0, 19) == 0);
      queue_random_packet(1'b1);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (byte_q.size() < 150);
      quiet = 1'b1;
      wait (byte_q.size() == 0 && !req_tvalid);
      wait (digest_q.size() == 0);
      repeat (600) @(posedge clock);
      if (fail_count == 0 && digest_q.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end
endmodule

/* files.f */
design/ipmd5_pkg.sv
design/ipmd5_core.sv
design/ip_packet_md5_identifier.sv
test/testbench.sv
